/* sv/vcg_pkg.sv */
package vcg_pkg;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_GRID = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] STATUS_DATA = 2'd0;
  localparam logic [1:0] STATUS_ACC  = 2'd1;
  localparam logic [1:0] STATUS_DROP = 2'd2;

  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [11:0]        table_index;
    logic signed [15:0] table_re;
    logic signed [15:0] table_im;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
  } vis_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [47:0] cell_re;
    logic signed [47:0] cell_im;
  } vis_out_t;

endpackage

/* sv/visibility_convolutional_gridder.sv */
// Convolutional gridder. Kernel words live in a table memory with one write and one read
// port, grid cells in a dual-port memory (one read, one write a cycle, registered read).
// After reset every grid cell is cleared, one cell a cycle, while no beat is taken;
// register writes are taken as ever. A kernel load is written as its beat is taken, a cell
// read fetches the cell and reports it, and a visibility whose window falls off the grid
// is dropped. Others are accumulated with one read-modify-write of a grid cell per cycle
// through a three-stage read, multiply, saturating-add pipeline, then a drain so the next
// beat sees every update. Coordinates go through one shared 33x33 multiplier in turn.
module visibility_convolutional_gridder import vcg_pkg::*; #(
  parameter int KERNEL_SUPPORT = 8,
  parameter int OVERSAMPLE     = 8,
  parameter int GRID_DIM       = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  vis_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output vis_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int KT  = OVERSAMPLE * OVERSAMPLE * KERNEL_SUPPORT * KERNEL_SUPPORT;
  localparam int KW  = (KT > 1) ? $clog2(KT) : 1;
  localparam int GW  = $clog2(GRID_DIM);
  localparam int GN  = 1 << (2 * GW);
  localparam int SW  = (KERNEL_SUPPORT > 1) ? $clog2(KERNEL_SUPPORT) : 1;
  localparam int PW  = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam int LIM = GRID_DIM - KERNEL_SUPPORT - 1;
  localparam logic [31:0] HALF = 32'h8000_0000;
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL_U, S_MUL_V, S_AXIS_V, S_CHECK, S_RUN, S_DRAIN, S_READ, S_DONE
  } state_t;

  state_t state;
  vis_in_t item;
  logic [31:0] scale_factor;
  logic [12:0] grid_offset_size;
  logic [2*GW-1:0] clr;

  logic signed [31:0] kmem_re [KT];
  logic signed [31:0] kmem_d;
  logic [95:0] gmem [GN];
  logic [95:0] grd;
  logic [2*GW-1:0] gra;
  logic gwe;
  logic [2*GW-1:0] gwa;
  logic [95:0] gwd;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [63:0] prod;

  logic signed [31:0] fl;
  logic [31:0] frac;
  logic rnd_up;
  logic signed [35:0] ax_corner;
  logic [36:0] tph;
  logic [5:0] ph6;
  logic [PW-1:0] ax_phase;

  logic signed [35:0] cu, cv;
  logic [PW-1:0] pu, pv;
  logic [KW-1:0] kaddr;
  logic [SW-1:0] wx, wy;
  logic [GW-1:0] row, col;

  logic s1_v, s2_v;
  logic [2*GW-1:0] s1_a, s2_a;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [47:0] g_re, g_im;
  logic signed [32:0] d_re, d_im;
  logic signed [48:0] sum_re, sum_im;
  logic signed [47:0] new_re, new_im;

  logic [1:0] res_status;
  logic [95:0] res_val;
  logic [15:0] cxe, cye;
  logic cell_ok;

  assign in_ready = (state == S_IDLE);

  assign cxe = 16'(in_data.cell_x);
  assign cye = 16'(in_data.cell_y);
  assign cell_ok = (int'(cxe) < GRID_DIM) && (int'(cye) < GRID_DIM);

  // shared coordinate multiplier
  assign ma = (state == S_IDLE) ? 33'(in_data.u_coord) : 33'(item.v_coord);
  assign mb = $signed({1'b0, scale_factor});
  assign mp = ma * mb;

  // pixel corner and phase from the registered product
  always_comb begin
    fl = prod[63:32];
    frac = prod[31:0];
    rnd_up = (frac > HALF) || ((frac == HALF) && fl[0]);
    ax_corner = 36'(fl) + 36'(rnd_up) + $signed(36'(grid_offset_size[12:1]))
                - 36'(KERNEL_SUPPORT / 2);
    tph = 37'(OVERSAMPLE) * 37'(frac);
    ph6 = 6'(tph[36:32]);
    if ((tph[31:0] > HALF) || ((tph[31:0] == HALF) && tph[32])) begin
      ph6 = ph6 + 6'd1;
    end
    if (int'(ph6) > OVERSAMPLE - 1) begin
      ax_phase = PW'(OVERSAMPLE - 1);
    end else begin
      ax_phase = PW'(ph6);
    end
  end

  assign row = GW'(cv) + GW'(wy);
  assign col = GW'(cu) + GW'(wx);

  always_comb begin
    if (state == S_IDLE) begin
      gra = {GW'(cye), GW'(cxe)};
    end else begin
      gra = {row, col};
    end
  end

  always_comb begin
    d_re = 33'(p_rr) - 33'(p_ii);
    d_im = 33'(p_ri) + 33'(p_ir);
    sum_re = 49'(g_re) + 49'(d_re);
    sum_im = 49'(g_im) + 49'(d_im);
    if (sum_re[48] != sum_re[47]) begin
      new_re = sum_re[48] ? ACC_MIN : ACC_MAX;
    end else begin
      new_re = sum_re[47:0];
    end
    if (sum_im[48] != sum_im[47]) begin
      new_im = sum_im[48] ? ACC_MIN : ACC_MAX;
    end else begin
      new_im = sum_im[47:0];
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      gwe = 1'b1;
      gwa = clr;
      gwd = '0;
    end else begin
      gwe = s2_v;
      gwa = s2_a;
      gwd = {new_re, new_im};
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (gwe) begin
      gmem[gwa] <= gwd;
    end
    grd <= gmem[gra];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_data.kind == KIND_LOAD
        && int'(in_data.table_index) < KT) begin
      kmem_re[KW'(in_data.table_index)] <= {in_data.table_re, in_data.table_im};
    end
    kmem_d <= kmem_re[kaddr];
  end

  // window pipeline
  always_ff @(posedge clk) begin
    p_rr <= item.sample_re * $signed(kmem_d[31:16]);
    p_ii <= item.sample_im * $signed(kmem_d[15:0]);
    p_ri <= item.sample_re * $signed(kmem_d[15:0]);
    p_ir <= item.sample_im * $signed(kmem_d[31:16]);
    g_re <= grd[95:48];
    g_im <= grd[47:0];
    s1_a <= {row, col};
    s2_a <= s1_a;
    prod <= mp[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      scale_factor <= 32'd65536;
      grid_offset_size <= 13'd256;
      out_valid <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SCALE) begin
          scale_factor <= cfg_data;
        end else begin
          grid_offset_size <= cfg_data[12:0];
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      s1_v <= 1'b0;
      s2_v <= s1_v;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            case (in_data.kind)
              KIND_GRID: state <= S_MUL_U;
              KIND_READ: begin
                if (cell_ok) begin
                  state <= S_READ;
                end else begin
                  res_status <= STATUS_DATA;
                  res_val <= '0;
                  state <= S_DONE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL_U: begin
          cu <= ax_corner;
          pu <= ax_phase;
          state <= S_MUL_V;
        end
        S_MUL_V: state <= S_AXIS_V;
        S_AXIS_V: begin
          cv <= ax_corner;
          pv <= ax_phase;
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_val <= '0;
          wx <= '0;
          wy <= '0;
          kaddr <= KW'((int'(pu) + int'(pv) * OVERSAMPLE) * KERNEL_SUPPORT * KERNEL_SUPPORT);
          if (cu < 0 || cu > 36'(LIM) || cv < 0 || cv > 36'(LIM)) begin
            res_status <= STATUS_DROP;
            state <= S_DONE;
          end else begin
            res_status <= STATUS_ACC;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          s1_v <= 1'b1;
          kaddr <= kaddr + 1'b1;
          if (int'(wx) == KERNEL_SUPPORT - 1) begin
            wx <= '0;
            wy <= wy + 1'b1;
            if (int'(wy) == KERNEL_SUPPORT - 1) begin
              state <= S_DRAIN;
            end
          end else begin
            wx <= wx + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!s1_v && !s2_v) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_status <= STATUS_DATA;
          res_val <= grd;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.status <= res_status;
            out_data.cell_re <= res_val[95:48];
            out_data.cell_im <= res_val[47:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
